>>> rtl/rah_pkg.sv
// ----------------------------------------------------------------------------
// rah_pkg
// Shared types, constants and helpers for the rotate-add-xor hash.
// ----------------------------------------------------------------------------
package rah_pkg;

   localparam int HalfRoundsDefault      = 4;
   localparam int MatrixRoundsDefault    = 2;
   localparam int DiffusionPassesDefault = 4;

   localparam logic OP_BYTE   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FOLD,
      ST_INJ_PRE,
      ST_INJ_LOOP,
      ST_HALF,
      ST_MATRIX,
      ST_DIFF,
      ST_FOLD_END,
      ST_FINAL,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] init_const(input logic [3:0] k);
      logic [31:0] r;
      case (k)
         4'd0:    r = 32'h6A09E667;
         4'd1:    r = 32'hBB67AE85;
         4'd2:    r = 32'h3C6EF372;
         4'd3:    r = 32'hA54FF53A;
         4'd4:    r = 32'h510E527F;
         4'd5:    r = 32'h9B05688C;
         4'd6:    r = 32'h1F83D9AB;
         4'd7:    r = 32'h5BE0CD19;
         4'd8:    r = 32'hC1059ED8;
         4'd9:    r = 32'h367CD507;
         4'd10:   r = 32'h3070DD17;
         4'd11:   r = 32'hF70E5939;
         4'd12:   r = 32'hFFC00B31;
         4'd13:   r = 32'h68581511;
         4'd14:   r = 32'h64F98FA7;
         default: r = 32'hBEFA4FA4;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] d;
      d = {v, v} << n;
      return d[63:32];
   endfunction

endpackage

>>> rtl/rah_if.sv
// ----------------------------------------------------------------------------
// rah_req_if / rah_rsp_if
// Valid/ready channels for message items and digest words.
// ----------------------------------------------------------------------------
interface rah_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;
   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface rah_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

>>> rtl/rotate_add_xor_hash_256.sv
// ----------------------------------------------------------------------------
// rotate_add_xor_hash_256
// Streaming 256-bit rotate-add-xor hash with a shared iterative mix unit.
// ----------------------------------------------------------------------------
// A byte is taken while the block is idle; after the 64th byte of a block the
// input is held off while the block is folded, the length is injected, the
// rounds run and the byte offset is updated. Finish first folds any pending
// bytes, then applies the final mix, then makes eight digest transfers.
// Synchronous reset restores the initial state and clears the length register.
module rotate_add_xor_hash_256
   import rah_pkg::*;
#(
   parameter int HALF_ROUNDS      = HalfRoundsDefault,
   parameter int MATRIX_ROUNDS    = MatrixRoundsDefault,
   parameter int DIFFUSION_PASSES = DiffusionPassesDefault
)
(
   input  logic        clock,
   input  logic        reset,
   rah_req_if.sink     req,
   rah_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   localparam int RndW = (HALF_ROUNDS > 1 || MATRIX_ROUNDS > 1 || DIFFUSION_PASSES > 1)
                         ? $clog2(HALF_ROUNDS + MATRIX_ROUNDS + DIFFUSION_PASSES + 1) : 1;

   state_type   state_ff, state_in;
   logic [31:0] hs_ff [16];
   logic [31:0] hs_in [16];
   logic [31:0] buf_ff [16];
   logic [31:0] buf_in [16];
   logic [31:0] schema_ff, schema_in;
   logic [31:0] comb_ff, comb_in;
   logic [6:0]  bib_ff, bib_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] len_ff;
   logic        fin_ff, fin_in;
   logic [RndW-1:0] rnd_ff, rnd_in;
   logic [4:0]  grp_ff, grp_in;
   logic [4:0]  step_ff, step_in;

   logic [3:0]  ia, ib, ic, id;
   logic [4:0]  sel;
   logic [31:0] ua, ub, uc, ud;

   rah_mix_unit u_mix (
      .step_sel (sel),
      .a_i (hs_ff[ia]), .b_i (hs_ff[ib]), .c_i (hs_ff[ic]), .d_i (hs_ff[id]),
      .a_o (ua), .b_o (ub), .c_o (uc), .d_o (ud)
   );

   // operand selection for the shared unit
   always_comb begin
      logic [3:0] j, p, q, r, s;
      logic [1:0] t;
      j = grp_ff[3:0];
      t = grp_ff[1:0];
      p = j; q = j; r = j; s = j;
      ia = j; ib = j; ic = j; id = j;
      sel = 5'd31;
      case (state_ff)
         ST_HALF: begin
            ia  = j;
            ib  = {j[3:2] + 2'd1, j[1:0] + 2'd1};
            sel = step_ff;
         end
         ST_MATRIX: begin
            if (!grp_ff[2]) begin
               p = {2'd0, t}; q = {2'd1, t}; r = {2'd2, t}; s = {2'd3, t};
            end else begin
               p = {2'd0, t};
               q = {2'd1, t + 2'd1};
               r = {2'd2, t + 2'd2};
               s = {2'd3, t + 2'd3};
            end
            if (step_ff < 5'd6) begin
               ia = q; ib = r; ic = p; sel = 5'd10 + step_ff;
            end else if (step_ff < 5'd12) begin
               ia = p; ib = r; ic = s; sel = step_ff + 5'd4;
            end else if (step_ff < 5'd16) begin
               ia = p; ib = q; ic = r; id = s; sel = step_ff + 5'd4;
            end else if (step_ff < 5'd22) begin
               ia = q; ib = s; ic = p; sel = step_ff - 5'd6;
            end else begin
               ia = q; ib = r; ic = s; sel = step_ff - 5'd12;
            end
         end
         ST_DIFF: begin
            ia  = j;
            ib  = step_ff[0] ? j + 4'd3 : j + 4'd7;
            sel = step_ff[0] ? 5'd21 : 5'd20;
         end
         default: ;
      endcase
   end

   // injection helpers
   logic [31:0] inj_sel, inj_seed, inj_kc, inj_hx, inj_sw;
   logic [3:0]  inj_k, inj_x;
   logic [1:0]  ii;
   always_comb begin
      ii       = grp_ff[1:0];
      inj_sel  = rotl(len_ff, 5'd15);
      inj_k    = inj_sel[3:0] * ({2'b00, ii} + 4'd1);
      inj_kc   = init_const(inj_k);
      inj_seed = comb_ff ^ rotl(schema_ff, 5'd11) ^ rotl(off_ff ^ comb_ff, 5'd23)
                 ^ ({30'd0, ii} * inj_kc);
      inj_x    = inj_seed[3:0] + {2'b00, ii};
      inj_hx   = hs_ff[inj_x] ^ rotl(comb_ff, 5'd9);
      inj_sw   = rotl((schema_ff + inj_hx) ^ inj_hx, 5'd19);
   end

   logic [31:0] pre_comb;
   always_comb begin
      pre_comb = schema_ff ^ rotl(off_ff, 5'd22) ^ rotl(len_ff << 3, 5'd17)
                 ^ rotl(len_ff >> 29, 5'd13);
   end

   logic [5:0] bp;
   assign bp = bib_ff[5:0];

   logic [5:0] last_step;
   always_comb begin
      case (state_ff)
         ST_HALF:   last_step = 6'd9;
         ST_MATRIX: last_step = 6'd27;
         ST_DIFF:   last_step = 6'd1;
         default:   last_step = 6'd0;
      endcase
   end
   logic step_done, grp_done;
   assign step_done = ({1'b0, step_ff} == last_step[5:0]) ;
   always_comb begin
      case (state_ff)
         ST_HALF:   grp_done = (grp_ff == 5'd15);
         ST_MATRIX: grp_done = (grp_ff == 5'd7);
         default:   grp_done = (grp_ff == 5'd15);
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req.valid) begin
               if (req.op == OP_FINISH)
                  state_in = (bib_ff != 7'd0) ? ST_FOLD : ST_FINAL;
               else if (bp == 6'd63)
                  state_in = ST_FOLD;
            end
         ST_FOLD:     if (grp_ff == 5'd15) state_in = ST_INJ_PRE;
         ST_INJ_PRE:  state_in = ST_INJ_LOOP;
         ST_INJ_LOOP:
            if (ii == 2'd3) begin
               if (HALF_ROUNDS > 0)          state_in = ST_HALF;
               else if (MATRIX_ROUNDS > 0)   state_in = ST_MATRIX;
               else if (DIFFUSION_PASSES > 0) state_in = ST_DIFF;
               else                          state_in = ST_FOLD_END;
            end
         ST_HALF:
            if (step_done && grp_done && rnd_ff == RndW'(HALF_ROUNDS - 1)) begin
               if (MATRIX_ROUNDS > 0)         state_in = ST_MATRIX;
               else if (DIFFUSION_PASSES > 0) state_in = ST_DIFF;
               else                           state_in = ST_FOLD_END;
            end
         ST_MATRIX:
            if (step_done && grp_done && rnd_ff == RndW'(MATRIX_ROUNDS - 1)) begin
               if (DIFFUSION_PASSES > 0) state_in = ST_DIFF;
               else                      state_in = ST_FOLD_END;
            end
         ST_DIFF:
            if (step_done && grp_done && rnd_ff == RndW'(DIFFUSION_PASSES - 1))
               state_in = ST_FOLD_END;
         ST_FOLD_END: state_in = fin_ff ? ST_FINAL : ST_IDLE;
         ST_FINAL:    state_in = ST_EMIT;
         ST_EMIT:     if (rsp.ready && grp_ff == 5'd7) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      logic [3:0] w;
      logic [3:0] fi;
      logic [31:0] shl;
      for (int k = 0; k < 16; k++) begin
         hs_in[k]  = hs_ff[k];
         buf_in[k] = buf_ff[k];
      end
      schema_in = schema_ff;
      comb_in   = comb_ff;
      bib_in    = bib_ff;
      off_in    = off_ff;
      fin_in    = fin_ff;
      rnd_in    = rnd_ff;
      grp_in    = grp_ff;
      step_in   = step_ff;
      w         = bp[5:2];
      fi        = grp_ff[3:0];
      shl       = 32'd0;
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = (state_ff == ST_EMIT);
      rsp.digest_word = hs_ff[grp_ff[2:0]];
      rsp.word_index  = grp_ff[2:0];
      rsp.last_word   = (grp_ff[2:0] == 3'd7);
      case (state_ff)
         ST_IDLE:
            if (req.valid) begin
               grp_in = 5'd0;
               step_in = 5'd0;
               rnd_in = '0;
               if (req.op == OP_BYTE) begin
                  case (bp[1:0])
                     2'd0: buf_in[w] = {24'd0, req.data_byte};
                     2'd1: buf_in[w] = buf_ff[w] | {16'd0, req.data_byte, 8'd0};
                     2'd2: buf_in[w] = buf_ff[w] | {8'd0, req.data_byte, 16'd0};
                     default: buf_in[w] = buf_ff[w] | {req.data_byte, 24'd0};
                  endcase
                  bib_in = {1'b0, bp} + 7'd1;
                  fin_in = 1'b0;
               end else begin
                  fin_in = 1'b1;
               end
            end
         ST_FOLD: begin
            hs_in[fi] = hs_ff[fi] ^ (buf_ff[fi] + rotl(buf_ff[fi + 4'd1], {1'b0, fi}));
            grp_in = grp_ff + 5'd1;
            if (grp_ff == 5'd15) grp_in = 5'd0;
         end
         ST_INJ_PRE: begin
            schema_in = schema_ff ^ pre_comb;
            comb_in   = pre_comb + (schema_ff ^ pre_comb);
         end
         ST_INJ_LOOP: begin
            hs_in[inj_x] = inj_hx;
            schema_in = inj_sw;
            comb_in   = comb_ff ^ inj_sw;
            grp_in    = (ii == 2'd3) ? 5'd0 : grp_ff + 5'd1;
         end
         ST_HALF, ST_MATRIX, ST_DIFF: begin
            // unused operand slots alias a live one, so they go first
            if (state_ff == ST_MATRIX) begin
               hs_in[id] = ud;
               hs_in[ic] = uc;
            end
            hs_in[ib] = ub;
            hs_in[ia] = ua;
            if (step_done) begin
               step_in = 5'd0;
               if (grp_done) begin
                  grp_in = 5'd0;
                  if (state_in != state_ff) rnd_in = '0;
                  else rnd_in = rnd_ff + RndW'(1);
               end else begin
                  grp_in = grp_ff + 5'd1;
               end
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         ST_FOLD_END: begin
            off_in = off_ff + {25'd0, bib_ff};
            bib_in = 7'd0;
            grp_in = 5'd0;
         end
         ST_FINAL: begin
            shl = len_ff << 17; hs_in[0]  = hs_ff[0]  ^ rotl(shl, 5'd6);
            shl = len_ff << 21; hs_in[4]  = hs_ff[4]  ^ rotl(shl, 5'd6);
            shl = len_ff << 25; hs_in[8]  = hs_ff[8]  ^ rotl(shl, 5'd6);
            shl = len_ff << 13; hs_in[12] = hs_ff[12] ^ rotl(shl, 5'd6);
            grp_in = 5'd0;
         end
         ST_EMIT:
            if (rsp.ready) begin
               grp_in = grp_ff + 5'd1;
               if (grp_ff == 5'd7) begin
                  for (int k = 0; k < 16; k++) begin
                     hs_in[k]  = init_const(4'(k));
                     buf_in[k] = 32'd0;
                  end
                  schema_in = init_const(4'd0);
                  bib_in    = 7'd0;
                  off_in    = 32'd0;
                  grp_in    = 5'd0;
               end
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         for (int k = 0; k < 16; k++) begin
            hs_ff[k]  <= init_const(4'(k));
            buf_ff[k] <= 32'd0;
         end
         schema_ff <= init_const(4'd0);
         comb_ff   <= 32'd0;
         bib_ff    <= 7'd0;
         off_ff    <= 32'd0;
         len_ff    <= 32'd0;
         fin_ff    <= 1'b0;
         rnd_ff    <= '0;
         grp_ff    <= 5'd0;
         step_ff   <= 5'd0;
      end else begin
         state_ff  <= state_in;
         hs_ff     <= hs_in;
         buf_ff    <= buf_in;
         schema_ff <= schema_in;
         comb_ff   <= comb_in;
         bib_ff    <= bib_in;
         off_ff    <= off_in;
         fin_ff    <= fin_in;
         rnd_ff    <= rnd_in;
         grp_ff    <= grp_in;
         step_ff   <= step_in;
         if (csr_write_enable) len_ff <= csr_write_data;
      end
   end

endmodule

>>> rtl/rah_mix_unit.sv
// ----------------------------------------------------------------------------
// rah_mix_unit
// Shared mixing datapath: one elementary step of a round per cycle.
// Operands a/b/c/d in, updated a/b/c/d out; step_sel selects the step.
// ----------------------------------------------------------------------------
module rah_mix_unit
   import rah_pkg::*;
(
   input  logic [4:0]  step_sel,
   input  logic [31:0] a_i,
   input  logic [31:0] b_i,
   input  logic [31:0] c_i,
   input  logic [31:0] d_i,
   output logic [31:0] a_o,
   output logic [31:0] b_o,
   output logic [31:0] c_o,
   output logic [31:0] d_o
);

   // steps 0..9: mix_pair (a,b); 10..15: tri_add (a=x,b=y,c=z)
   // 16..19: quad_mix rows; 20: diffusion xor, 21: diffusion add (a=s[i],b=src)
   always_comb begin
      a_o = a_i;
      b_o = b_i;
      c_o = c_i;
      d_o = d_i;
      case (step_sel)
         5'd0:  a_o = a_i + (b_i | a_i);
         5'd1:  b_o = b_i + (b_i | a_i);
         5'd2:  a_o = a_i + rotl(a_i, 5'd13);
         5'd3:  b_o = b_i + rotl(b_i, 5'd14);
         5'd4:  b_o = b_i ^ rotl(b_i, 5'd15);
         5'd5:  a_o = a_i + rotl(a_i, 5'd26);
         5'd6:  a_o = a_i + rotl(a_i, 5'd11);
         5'd7:  b_o = b_i + rotl(b_i, 5'd10);
         5'd8:  b_o = b_i ^ rotl(a_i + b_i, 5'd23);
         5'd9:  a_o = a_i ^ rotl(b_i + a_i, 5'd10);
         5'd10: a_o = a_i + (c_i + b_i);
         5'd11: b_o = b_i + (a_i + c_i);
         5'd12: c_o = c_i + (a_i + b_i);
         5'd13: a_o = a_i + rotl(c_i, 5'd19);
         5'd14: b_o = b_i + rotl(a_i, 5'd13);
         5'd15: c_o = c_i + rotl(b_i, 5'd8);
         5'd16: begin
            b_o = rotl(b_i ^ d_i, 5'd9);
            a_o = rotl(a_i + b_i, 5'd6);
         end
         5'd17: begin
            a_o = a_i ^ (c_i + d_i);
            d_o = rotl(d_i, 5'd12);
            c_o = rotl(c_i + d_i, 5'd13);
         end
         5'd18: begin
            a_o = rotl(a_i + b_i, 5'd25);
            c_o = c_i ^ d_i;
            b_o = rotl(d_i, 5'd14);
         end
         5'd19: begin
            a_o = a_i ^ b_i;
            d_o = rotl(b_i, 5'd23);
            c_o = rotl(c_i + d_i, 5'd30);
         end
         5'd20: a_o = a_i ^ rotl(b_i, 5'd11);
         5'd21: a_o = a_i + rotl(b_i, 5'd17);
         default: ;
      endcase
   end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rotate_add_xor_hash_256. Message bytes and finish
// items go in over the request channel. A local digest predictor keeps its
// own hash state, block words and length. Every digest word transfer is
// checked against the oldest predicted word. The bench covers directed
// corner cases, random messages, changes of the length register, random
// idling on both channels and a long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
   import rah_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NHalf   = HalfRoundsDefault;
   localparam int NMatrix = MatrixRoundsDefault;
   localparam int NDiff   = DiffusionPassesDefault;
   localparam int DrainWait    = 1200;
   localparam int StallLimit   = 20000;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_t;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [31:0] csr_write_data;

   rah_req_if req ();
   rah_rsp_if rsp ();

   rotate_add_xor_hash_256 dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   const logic [31:0] seed_words [16] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19,
      32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
      32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};

   logic [31:0] hstate [16];
   logic [31:0] blk_words [16];
   logic [31:0] schema;
   logic [31:0] fill_count;
   logic [31:0] byte_offset;
   logic [31:0] msg_len;

   digest_entry_t digest_q [$];
   int errors;
   int src_idle;
   int snk_idle;
   int snk_hold;
   int quiet_cycles;

   // ------------------------------------------------------------ predictor
   function automatic logic [31:0] rot32(input logic [31:0] v, input int n);
      int m;
      m = n & 31;
      if (m == 0) return v;
      return (v << m) | (v >> (32 - m));
   endfunction

   function automatic void mix_pair(input int ia, input int ib);
      logic [31:0] a, b;
      a = hstate[ia]; b = hstate[ib];
      a += (b | a);
      b += (b | a);
      a += rot32(a, 13);
      b += rot32(b, 14);
      b ^= rot32(b, 15);
      a += rot32(a, 26);
      a += rot32(a, 11);
      b += rot32(b, 10);
      b ^= rot32(a + b, 23);
      a ^= rot32(b + a, 10);
      hstate[ia] = a; hstate[ib] = b;
   endfunction

   function automatic void tri_add(input int ix, input int iy, input int iz);
      logic [31:0] x, y, z;
      x = hstate[ix]; y = hstate[iy]; z = hstate[iz];
      x += (z + y);
      y += (x + z);
      z += (x + y);
      x += rot32(z, 19);
      y += rot32(x, 13);
      z += rot32(y, 8);
      hstate[ix] = x; hstate[iy] = y; hstate[iz] = z;
   endfunction

   function automatic void quad_mix(input int ia, input int ib, input int ic, input int id);
      logic [31:0] a, b, c, d;
      a = hstate[ia]; b = hstate[ib]; c = hstate[ic]; d = hstate[id];
      a += b; b ^= d; b = rot32(b, 9);  a = rot32(a, 6);
      c += d; a ^= c; d = rot32(d, 12); c = rot32(c, 13);
      a += b; c ^= d; b = rot32(d, 14); a = rot32(a, 25);
      c += d; a ^= b; d = rot32(b, 23); c = rot32(c, 30);
      hstate[ia] = a; hstate[ib] = b; hstate[ic] = c; hstate[id] = d;
   endfunction

   function automatic void matrix_step(input int a, input int b, input int c, input int d);
      tri_add(b, c, a);
      tri_add(a, c, d);
      quad_mix(a, b, c, d);
      tri_add(b, d, a);
      tri_add(b, c, d);
   endfunction

   function automatic void inject_len(input logic [31:0] blk);
      logic [31:0] lo, hi, comb, sel, k, seed, x;
      lo = msg_len << 3;
      hi = msg_len >> 29;
      comb = schema;
      sel = rot32(msg_len, 15);
      comb ^= rot32(blk, 22);
      comb ^= rot32(lo, 17);
      comb ^= rot32(hi, 13);
      schema ^= comb;
      comb += schema;
      for (int i = 0; i < 4; i++) begin
         k = ((i + 1) * sel) & 32'd15;
         seed = comb ^ rot32(schema, 11) ^ rot32(blk ^ comb, 23) ^ (i * seed_words[k]);
         x = ((seed & 32'd15) + i) & 32'd15;
         hstate[x] ^= rot32(comb, 9);
         schema += hstate[x];
         schema ^= hstate[x];
         schema = rot32(schema, 19);
         comb ^= schema;
      end
   endfunction

   function automatic void run_rounds();
      for (int r = 0; r < NHalf; r++)
         for (int j = 0; j < 16; j += 4) begin
            mix_pair(j, (j + 5) & 15);
            mix_pair(j + 1, (j + 6) & 15);
            mix_pair(j + 2, (j + 7) & 15);
            mix_pair(j + 3, (j + 4) & 15);
         end
      for (int r = 0; r < NMatrix; r++) begin
         matrix_step(0, 4, 8, 12);
         matrix_step(1, 5, 9, 13);
         matrix_step(2, 6, 10, 14);
         matrix_step(3, 7, 11, 15);
         matrix_step(0, 5, 10, 15);
         matrix_step(1, 6, 11, 12);
         matrix_step(2, 7, 8, 13);
         matrix_step(3, 4, 9, 14);
      end
      for (int r = 0; r < NDiff; r++)
         for (int i = 0; i < 16; i++) begin
            hstate[i] ^= rot32(hstate[(i + 7) & 15], 11);
            hstate[i] += rot32(hstate[(i + 3) & 15], 17);
         end
   endfunction

   function automatic void fold_words();
      for (int i = 0; i < 16; i++)
         hstate[i] ^= blk_words[i] + rot32(blk_words[(i + 1) & 15], i);
      inject_len(byte_offset);
      run_rounds();
      byte_offset += fill_count;
      fill_count = 0;
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 16; i++) begin
         hstate[i] = seed_words[i];
         blk_words[i] = '0;
      end
      schema = seed_words[0];
      fill_count = 0;
      byte_offset = 0;
   endfunction

   function automatic void predict_digest(input logic op, input logic [7:0] data);
      int p;
      digest_entry_t e;
      if (op == OP_BYTE) begin
         p = fill_count & 63;
         if ((p & 3) == 0) blk_words[p >> 2] = {24'd0, data};
         else blk_words[p >> 2] |= {24'd0, data} << (8 * (p & 3));
         fill_count = p + 1;
         if (fill_count == 64) fold_words();
      end else begin
         if (fill_count != 0) fold_words();
         hstate[0]  ^= rot32(msg_len << 17, 6);
         hstate[4]  ^= rot32(msg_len << 21, 6);
         hstate[8]  ^= rot32(msg_len << 25, 6);
         hstate[12] ^= rot32(msg_len << 13, 6);
         for (int k = 0; k < 8; k++) begin
            e.word = hstate[k];
            e.index = 3'(k);
            e.last = (k == 7);
            digest_q.push_back(e);
         end
         restart_message();
      end
   endfunction

   // ------------------------------------------------------------ clock/reset
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   // ------------------------------------------------------------ result side
   always @(posedge clock) begin
      digest_entry_t e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (digest_q.size() == 0) begin
            report("unexpected transfer", rsp.digest_word, 32'd0);
         end else begin
            e = digest_q.pop_front();
            if (rsp.digest_word !== e.word) report("digest_word", rsp.digest_word, e.word);
            if (rsp.word_index !== e.index)
               report("word_index", {29'd0, rsp.word_index}, {29'd0, e.index});
            if (rsp.last_word !== e.last)
               report("last_word", {31'd0, rsp.last_word}, {31'd0, e.last});
         end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
         $display("testbench: errors");
         $finish;
      end
      if (snk_hold > 0) begin
         snk_hold <= snk_hold - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= snk_idle);
      end
   end

   // ------------------------------------------------------------ stimulus
   task automatic send_item(input logic op, input logic [7:0] data);
      while ($urandom_range(99) < src_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.op <= op;
      req.data_byte <= data;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_digest(op, data);
   endtask

   task automatic send_message(input int nbytes);
      for (int i = 0; i < nbytes; i++) send_item(OP_BYTE, 8'($urandom));
      send_item(OP_FINISH, 8'($urandom));
   endtask

   task automatic write_length(input logic [31:0] value);
      req.valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      msg_len = value;
   endtask

   task automatic test_directed();
      send_item(OP_FINISH, 8'hFF);            // nothing pending
      write_length(32'hFFFFFFFF);
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, 8'hA5);              // partial word, zero fill
      send_item(OP_FINISH, 8'h00);
      write_length(32'd0);
      for (int i = 0; i < 64; i++) send_item(OP_BYTE, 8'(i * 4 + 3));
      send_item(OP_FINISH, 8'h00);            // full block then nothing pending
      write_length(32'd70);
      send_message(70);                       // short block keeps stale words
   endtask

   task automatic test_random(input int budget);
      int n;
      while (budget > 0) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(130, 64) : $urandom_range(40);
         if ($urandom_range(3) == 0) write_length($urandom);
         else if ($urandom_range(2) == 0) write_length(32'(n));
         send_message(n);
         budget -= n + 1;
      end
   endtask

   task automatic test_backpressure();
      req.valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      src_idle = 0;
      snk_hold = 3000;
      send_message(3);
      send_message(0);
      send_message(5);
   endtask

   initial begin
      errors = 0;
      snk_hold = 0;
      quiet_cycles = 0;
      src_idle = 38;
      snk_idle = 68;
      reset = 1'b1;
      req.valid = 1'b0;
      req.op = OP_BYTE;
      req.data_byte = '0;
      rsp.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      msg_len = '0;
      restart_message();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(60);
      src_idle = 68;
      snk_idle = 38;
      test_random(60);
      src_idle = 0;
      snk_idle = 0;
      test_random(60);
      test_backpressure();
      test_random(20);
      req.valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
